// ----- rtl/core/ltd_pkg.sv -----
// Package for the LRU tag directory: request and response structs,
// request kind and status codes. No dependencies.
package ltd_pkg;

  localparam int unsigned KEY_W  = 32;
  localparam int unsigned SLOT_W = 5;

  // Request kinds
  localparam logic [1:0] KIND_PRIME_SONG = 2'd0;
  localparam logic [1:0] KIND_PRIME_KEY  = 2'd1;
  localparam logic [1:0] KIND_GET        = 2'd2;
  localparam logic [1:0] KIND_CLEAR      = 2'd3;

  // Response status codes
  localparam logic [2:0] ST_IGNORED  = 3'd0;
  localparam logic [2:0] ST_REFRESH  = 3'd1;
  localparam logic [2:0] ST_FILL     = 3'd2;
  localparam logic [2:0] ST_EVICT    = 3'd3;
  localparam logic [2:0] ST_GET_HIT  = 3'd4;
  localparam logic [2:0] ST_GET_MISS = 3'd5;
  localparam logic [2:0] ST_CLEARED  = 3'd6;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [KEY_W-1:0] lookup_key;
    logic                    art_ok;
  } ltd_req_t;

  typedef struct packed {
    logic [2:0]              status;
    logic                    hit;
    logic [SLOT_W-1:0]       slot_index;
    logic                    evicted_valid;
    logic signed [KEY_W-1:0] evicted_key;
  } ltd_rsp_t;

endpackage

// ----- rtl/core/lru_tag_directory.sv -----
// LRU tag directory top level: fully associative key directory with
// least-recently-used replacement, key/stamp store in a single-port RAM.
// Depends on ltd_pkg.
//
//  channel | ports                  | handshake
//  --------+------------------------+-------------------------------------
//  request | start, busy, in_req    | taken when start is high, busy low
//  result  | out_strobe, out_rsp    | valid for one cycle, cannot stall
//
// Prime and get requests read every key/stamp RAM entry in turn (one port,
// one entry a cycle), register the last read data, then write back in
// S_WRITE and raise the result strobe. Busy drops with the strobe, so the
// next request can be taken while the strobe is high.
// Invalidate and an ignored prime give their result the cycle after
// acceptance. Synchronous active-low reset clears valid and art marks and
// the use counter; key/stamp RAM contents are left as they are.
// The result side cannot stall; busy holds further requests off.

module lru_tag_directory
  import ltd_pkg::*;
#(
  parameter int unsigned SLOTS      = 32,
  parameter int unsigned STAMP_BITS = 64
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  ltd_req_t in_req,
  output logic     out_strobe,
  output ltd_rsp_t out_rsp
);

  localparam int unsigned IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned WORD_W = KEY_W + STAMP_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SCAN  = 3'b010,
    S_WRITE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Request held for the duration of the operation
  logic [1:0]       kind_r;
  logic [KEY_W-1:0] key_r;
  logic             art_in_r;

  // Per-entry marks in flops, key and stamp in RAM
  logic [SLOTS-1:0]      valid_r;
  logic [SLOTS-1:0]      art_r;
  logic [STAMP_BITS-1:0] cnt_r;
  logic [WORD_W-1:0]     mem [SLOTS];
  logic [WORD_W-1:0]     rd_data_r;

  // Scan control
  logic [IDX_W-1:0] iss_idx_r;
  logic             iss_done_r;
  logic             pv_r;
  logic [IDX_W-1:0] pidx_r;
  logic             rd_en;

  // Scan results
  logic                  found_r;
  logic [IDX_W-1:0]      match_idx_r;
  logic                  free_found_r;
  logic [IDX_W-1:0]      free_idx_r;
  logic [IDX_W-1:0]      min_idx_r;
  logic [STAMP_BITS-1:0] min_stamp_r;
  logic [KEY_W-1:0]      min_key_r;

  // Write-back decision
  logic                  mem_we;
  logic [IDX_W-1:0]      wr_idx;
  logic [STAMP_BITS-1:0] stamp_nxt;
  logic                  set_valid;
  logic                  bump;
  ltd_rsp_t              rsp_nxt;

  logic                  out_strobe_r;
  ltd_rsp_t              out_rsp_r;

  logic             accept;
  logic [KEY_W-1:0] rd_key;
  logic [STAMP_BITS-1:0] rd_stamp;
  logic             rd_valid;

  assign accept    = start && (state_r == S_IDLE);
  assign busy      = (state_r != S_IDLE);
  assign rd_en     = (state_r == S_SCAN) && !iss_done_r;
  assign rd_key    = rd_data_r[WORD_W-1:STAMP_BITS];
  assign rd_stamp  = rd_data_r[STAMP_BITS-1:0];
  assign rd_valid  = valid_r[pidx_r];
  assign stamp_nxt = cnt_r + STAMP_BITS'(1);

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && in_req.kind != KIND_CLEAR &&
            !(in_req.kind == KIND_PRIME_SONG && in_req.lookup_key[KEY_W-1])) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (pv_r && pidx_r == LAST_IDX) begin
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Decide the write-back and the response at the end of the scan
  always_comb begin
    mem_we    = 1'b0;
    wr_idx    = match_idx_r;
    set_valid = 1'b0;
    bump      = 1'b0;
    rsp_nxt   = '0;
    if (kind_r == KIND_GET) begin
      if (found_r && art_r[match_idx_r]) begin
        mem_we             = 1'b1;
        bump               = 1'b1;
        rsp_nxt.status     = ST_GET_HIT;
        rsp_nxt.hit        = 1'b1;
        rsp_nxt.slot_index = SLOT_W'(match_idx_r);
      end else begin
        rsp_nxt.status     = ST_GET_MISS;
      end
    end else if (found_r) begin
      mem_we             = 1'b1;
      bump               = 1'b1;
      rsp_nxt.status     = ST_REFRESH;
      rsp_nxt.slot_index = SLOT_W'(match_idx_r);
    end else begin
      mem_we    = 1'b1;
      bump      = 1'b1;
      set_valid = 1'b1;
      if (free_found_r) begin
        wr_idx         = free_idx_r;
        rsp_nxt.status = ST_FILL;
      end else begin
        wr_idx                = min_idx_r;
        rsp_nxt.status        = ST_EVICT;
        rsp_nxt.evicted_valid = 1'b1;
        rsp_nxt.evicted_key   = min_key_r;
      end
      rsp_nxt.slot_index = SLOT_W'(wr_idx);
    end
  end

  // Key/stamp RAM: one access a cycle, registered read data
  always_ff @(posedge clk) begin
    if (state_r == S_WRITE && mem_we) begin
      mem[wr_idx] <= {key_r, stamp_nxt};
    end else if (rd_en) begin
      rd_data_r <= mem[iss_idx_r];
    end
  end

  // Control state, marks and counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      art_r        <= '0;
      cnt_r        <= '0;
      iss_done_r   <= 1'b0;
      pv_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      pv_r         <= rd_en;
      if (accept) begin
        iss_done_r <= 1'b0;
        if (in_req.kind == KIND_CLEAR) begin
          valid_r      <= '0;
          art_r        <= '0;
          cnt_r        <= '0;
          out_strobe_r <= 1'b1;
        end else if (in_req.kind == KIND_PRIME_SONG && in_req.lookup_key[KEY_W-1]) begin
          out_strobe_r <= 1'b1;
        end
      end
      // Stop reading after the last entry
      if (rd_en && iss_idx_r == LAST_IDX) begin
        iss_done_r <= 1'b1;
      end
      if (state_r == S_WRITE) begin
        out_strobe_r <= 1'b1;
        if (bump) begin
          cnt_r <= stamp_nxt;
        end
        if (set_valid) begin
          valid_r[wr_idx] <= 1'b1;
          art_r[wr_idx]   <= art_in_r;
        end
      end
    end
  end

  // Datapath: request hold, scan tracking, response register
  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r       <= in_req.kind;
      key_r        <= in_req.lookup_key;
      art_in_r     <= in_req.art_ok;
      found_r      <= 1'b0;
      free_found_r <= 1'b0;
      iss_idx_r    <= '0;
      out_rsp_r    <= '0;
      if (in_req.kind == KIND_CLEAR) begin
        out_rsp_r.status <= ST_CLEARED;
      end
    end
    if (rd_en && iss_idx_r != LAST_IDX) begin
      iss_idx_r <= iss_idx_r + IDX_W'(1);
    end
    pidx_r <= iss_idx_r;
    // Track first match, first free slot and oldest valid entry
    if (pv_r) begin
      if (rd_valid && rd_key == key_r && !found_r) begin
        found_r     <= 1'b1;
        match_idx_r <= pidx_r;
      end
      if (!rd_valid && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= pidx_r;
      end
      if (rd_valid && (pidx_r == '0 || rd_stamp < min_stamp_r)) begin
        min_idx_r   <= pidx_r;
        min_stamp_r <= rd_stamp;
        min_key_r   <= rd_key;
      end
    end
    if (state_r == S_WRITE) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_rsp    = out_rsp_r;

  // End of scan always produces a result next cycle
  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE |=> out_strobe)
    else $error("write-back without result strobe");

  // Invalidate answers with the cleared status and a zero use counter
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_req.kind == KIND_CLEAR |=>
      out_strobe && out_rsp.status == ST_CLEARED && cnt_r == '0)
    else $error("invalidate did not report cleared");

  // A hit is only reported with the get-hit status
  a_hit_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_rsp.hit |-> out_rsp.status == ST_GET_HIT)
    else $error("hit flag with wrong status");

  // An eviction happens only when no slot was free
  a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WRITE && set_valid && !free_found_r |-> valid_r == '1)
    else $error("eviction while a slot was free");

endmodule

// ----- tb/tb_lru_tag_directory.sv -----
// Self-checking testbench for lru_tag_directory: directed and random requests
// against a shadow copy of the directory held in a small scoreboard class.
// Depends on ltd_pkg and the lru_tag_directory top level.
module tb_lru_tag_directory
  import ltd_pkg::*;
();

  localparam int DIR_SLOTS    = 32;
  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_ITEMS   = 150;
  localparam int POOL_SIZE    = 40;
  localparam int DRAIN_CYCLES = DIR_SLOTS + 8;
  localparam int CYCLE_LIMIT  = 400000;

  // Shadow directory: predicts each response and checks the ones that arrive
  class dir_shadow;
    bit          slot_live[DIR_SLOTS];
    bit          slot_art[DIR_SLOTS];
    logic [31:0] slot_tag[DIR_SLOTS];
    logic [63:0] slot_age[DIR_SLOTS];
    logic [63:0] use_count;
    ltd_rsp_t    expected_rsp[$];
    int          mismatches;

    function new();
      for (int i = 0; i < DIR_SLOTS; i++) begin
        slot_live[i] = 1'b0;
        slot_art[i]  = 1'b0;
        slot_tag[i]  = '0;
        slot_age[i]  = '0;
      end
      use_count  = '0;
      mismatches = 0;
    endfunction

    function int match_slot(logic [31:0] key);
      for (int i = 0; i < DIR_SLOTS; i++)
        if (slot_live[i] && slot_tag[i] == key) return i;
      return -1;
    endfunction

    function int pending();
      return expected_rsp.size();
    endfunction

    // Apply one accepted request to the shadow state and queue its response
    function void note_request(ltd_req_t req);
      ltd_rsp_t    rsp;
      logic [31:0] key;
      int          s;
      rsp = '0;
      key = req.lookup_key;
      case (req.kind)
        KIND_CLEAR: begin
          for (int i = 0; i < DIR_SLOTS; i++) begin
            slot_live[i] = 1'b0;
            slot_art[i]  = 1'b0;
          end
          use_count  = '0;
          rsp.status = ST_CLEARED;
        end
        KIND_GET: begin
          s = match_slot(key);
          if (s >= 0 && slot_art[s]) begin
            use_count      = use_count + 64'd1;
            slot_age[s]    = use_count;
            rsp.status     = ST_GET_HIT;
            rsp.hit        = 1'b1;
            rsp.slot_index = s[SLOT_W-1:0];
          end else begin
            rsp.status = ST_GET_MISS;
          end
        end
        default: begin
          if (req.kind == KIND_PRIME_SONG && key[31]) begin
            rsp.status = ST_IGNORED;
          end else begin
            s = match_slot(key);
            if (s >= 0) begin
              // refresh only: the art mark keeps its old value
              use_count   = use_count + 64'd1;
              slot_age[s] = use_count;
              rsp.status  = ST_REFRESH;
            end else begin
              // lowest free slot, else oldest stamp with lowest index on ties
              s = 0;
              for (int i = 0; i < DIR_SLOTS; i++) begin
                if (!slot_live[i]) begin
                  s = i;
                  break;
                end
                if (slot_age[i] < slot_age[s]) s = i;
              end
              if (slot_live[s]) begin
                rsp.status        = ST_EVICT;
                rsp.evicted_valid = 1'b1;
                rsp.evicted_key   = slot_tag[s];
              end else begin
                rsp.status = ST_FILL;
              end
              use_count    = use_count + 64'd1;
              slot_live[s] = 1'b1;
              slot_tag[s]  = key;
              slot_age[s]  = use_count;
              slot_art[s]  = req.art_ok;
            end
            rsp.slot_index = s[SLOT_W-1:0];
          end
        end
      endcase
      expected_rsp.push_back(rsp);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        mismatches++;
      end
    endfunction

    // Compare one strobed response with the oldest prediction
    function void check_response(ltd_rsp_t got);
      ltd_rsp_t want;
      if (expected_rsp.size() == 0) begin
        $error("out_rsp: response strobed with no request outstanding");
        mismatches++;
        return;
      end
      want = expected_rsp.pop_front();
      compare_field("status", 32'(want.status), 32'(got.status));
      compare_field("hit", 32'(want.hit), 32'(got.hit));
      compare_field("slot_index", 32'(want.slot_index), 32'(got.slot_index));
      compare_field("evicted_valid", 32'(want.evicted_valid), 32'(got.evicted_valid));
      compare_field("evicted_key", want.evicted_key, got.evicted_key);
    endfunction
  endclass

  logic     clk;
  logic     rst_n  = 1'b0;
  logic     start  = 1'b0;
  logic     busy;
  ltd_req_t in_req = '0;
  logic     out_strobe;
  ltd_rsp_t out_rsp;

  dir_shadow   sb;
  logic [31:0] key_pool[POOL_SIZE];
  bit          idle_on;
  int          cycles;

  lru_tag_directory #(
    .SLOTS      (DIR_SLOTS),
    .STAMP_BITS (64)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_req     (in_req),
    .out_strobe (out_strobe),
    .out_rsp    (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("lru_tag_directory: mismatch");
      $finish;
    end
  end

  // Check every strobed response
  always @(posedge clk) begin
    if (rst_n && out_strobe) sb.check_response(out_rsp);
  end

  // Present one request, hold it until taken, then maybe idle for a burst
  task automatic issue_request(logic [1:0] kind, logic [31:0] key, logic art);
    ltd_req_t req;
    req.kind       = kind;
    req.lookup_key = key;
    req.art_ok     = art;
    start  <= 1'b1;
    in_req <= req;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(req);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  initial begin
    logic [1:0]  kind;
    logic [31:0] key;
    int          pick;
    sb      = new();
    cycles  = 0;
    idle_on = 1'b1;
    // small indices give refreshes and hits, the rest spread over all bits
    for (int i = 0; i < POOL_SIZE; i++)
      key_pool[i] = (i < 20) ? 32'(i) : $urandom;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty lookup, negative song index, art kept on refresh, clear
    issue_request(KIND_GET,        32'd5,          1'b1);
    issue_request(KIND_PRIME_SONG, 32'd0,          1'b1);
    issue_request(KIND_PRIME_SONG, 32'h8000_0000,  1'b1);
    issue_request(KIND_PRIME_SONG, 32'hffff_ffff,  1'b0);
    issue_request(KIND_PRIME_SONG, 32'h7fff_ffff,  1'b0);
    issue_request(KIND_PRIME_KEY,  32'h8000_0000,  1'b1);
    issue_request(KIND_PRIME_KEY,  32'hffff_ffff,  1'b0);
    issue_request(KIND_GET,        32'd0,          1'b0);
    issue_request(KIND_GET,        32'h7fff_ffff,  1'b1);
    issue_request(KIND_PRIME_SONG, 32'h7fff_ffff,  1'b1);
    issue_request(KIND_GET,        32'h7fff_ffff,  1'b0);
    issue_request(KIND_PRIME_KEY,  32'd0,          1'b0);
    issue_request(KIND_GET,        32'd0,          1'b1);
    issue_request(KIND_GET,        32'h8000_0000,  1'b0);
    issue_request(KIND_GET,        32'd12345,      1'b1);
    issue_request(KIND_PRIME_KEY,  32'h5a5a_a5a5,  1'b1);
    issue_request(KIND_CLEAR,      32'hffff_ffff,  1'b1);
    issue_request(KIND_GET,        32'd0,          1'b1);
    issue_request(KIND_PRIME_KEY,  32'hffff_ffff,  1'b1);
    issue_request(KIND_GET,        32'hffff_ffff,  1'b0);
    issue_request(KIND_CLEAR,      32'd0,          1'b0);

    // Random: mostly pooled keys so the directory fills, evicts and hits
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS - CALM_ITEMS) idle_on = 1'b0;
      pick = $urandom_range(0, 199);
      if (pick < 66)       kind = KIND_PRIME_SONG;
      else if (pick < 126) kind = KIND_PRIME_KEY;
      else if (pick < 199) kind = KIND_GET;
      else                 kind = KIND_CLEAR;
      pick = $urandom_range(0, 99);
      if (pick < 70)      key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
      else if (pick < 85) key = $urandom;
      else if (pick < 95) key = 32'($urandom_range(0, 63));
      else                key = {1'b1, 31'($urandom)};
      issue_request(kind, key, $urandom_range(0, 9) < 7);
    end
    start <= 1'b0;

    // Drain outstanding responses, then watch for strays
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("lru_tag_directory: match");
    end else begin
      $display("lru_tag_directory: mismatch");
    end
    $finish;
  end

endmodule
